### hw/rtl/sas_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and types of the selective-ack sender
// no dependencies
package sas_pkg;

	localparam int MAX_CHUNKS_DEF = 64;
	localparam int IDX_W          = 6;
	localparam int BITMAP_W       = 64;
	localparam int BITMAP_BYTES   = 8;

	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
	localparam logic [3:0]  RETRIES_RESET = 4'd5;

	// input modes
	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_TXREP = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;
	localparam logic [1:0] MODE_ACK   = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_TX   = 2'd1;
	localparam logic [1:0] KIND_OK   = 2'd2;
	localparam logic [1:0] KIND_FAIL = 2'd3;

	// register indexes
	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_RETRIES = 1'b1;

	typedef struct packed {
		logic [1:0]          mode;
		logic [6:0]          total_chunks;
		logic                reliable;
		logic                tx_ok;
		logic [15:0]         ack_message_id;
		logic [BITMAP_W-1:0] ack_bitmap;
		logic [3:0]          ack_bytes;
	} in_word_t;

	// result of the lowest-pending search
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             last;
	} pick_t;

endpackage

### hw/rtl/sas_if.sv
`timescale 1ns / 1ps
// valid/ready channels of the selective-ack sender: event words in, result words out
// no dependencies
interface sas_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [6:0]  total_chunks;
	logic        reliable;
	logic        tx_ok;
	logic [15:0] ack_message_id;
	logic [63:0] ack_bitmap;
	logic [3:0]  ack_bytes;

	modport source (output valid, mode, total_chunks, reliable, tx_ok, ack_message_id,
		ack_bitmap, ack_bytes, input ready);
	modport sink (input valid, mode, total_chunks, reliable, tx_ok, ack_message_id,
		ack_bitmap, ack_bytes, output ready);
endinterface

interface sas_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [5:0]  chunk_index;
	logic        ack_request;
	logic [15:0] message_id;

	modport source (output valid, kind, chunk_index, ack_request, message_id, input ready);
	modport sink (input valid, kind, chunk_index, ack_request, message_id, output ready);
endinterface

### hw/rtl/sas_pick.sv
`timescale 1ns / 1ps
// lowest-set-bit search over the pending chunk mask, with the mask left after release
// depends on sas_pkg
module sas_pick
	import sas_pkg::*;
#(
	parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
	input  logic [MAX_CHUNKS-1:0] mask,
	output pick_t                 pick,
	output logic [MAX_CHUNKS-1:0] rest
);

	always_comb begin
		logic found;
		found     = 1'b0;
		pick.idx  = '0;
		rest      = mask;
		for (int i = 0; i < MAX_CHUNKS; i++) begin
			if (mask[i] && !found) begin
				pick.idx = IDX_W'(i);
				rest[i]  = 1'b0;
				found    = 1'b1;
			end
		end
		pick.last = (rest == '0);
	end

endmodule

### hw/rtl/selective_ack_sender_arq_core.sv
`timescale 1ns / 1ps
// top level of the selective-repeat sender: event register, message state, result register
// depends on sas_pkg, sas_if (sas_in_if, sas_out_if) and sas_pick
//
//  channel   | dir | fields                                                   | handshake
//  ----------+-----+----------------------------------------------------------+-----------
//  in_ch     | in  | mode total_chunks reliable tx_ok ack_message_id          | valid/ready
//            |     | ack_bitmap ack_bytes                                     |
//  out_ch    | out | kind chunk_index ack_request message_id                  | valid/ready
//  cfg       | in  | cfg_we cfg_index cfg_data (0 timeout_ticks, 1 retry limit) | write only
//
// one word per cycle while out_ch takes results; an accepted word is registered in the event
// register, then its result in the result register that drives out_ch
// every event gives exactly one result word, kind none included
// the pending-chunk priority search sets the path from the event register to the result
// register; it is shared by start, transmit report and acknowledgement
// arst_n clears the message state, id counter to 1, config registers to 1000 ticks and 5 retries
// out_ch stalls hold the result and the event register; in_ch.ready drops while both are full
module selective_ack_sender_arq_core
	import sas_pkg::*;
#(
	parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sas_in_if.sink      in_ch,
	sas_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_CHUNKS + 1);

	// message phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_SEND = 2'd1;
	localparam logic [1:0] PH_WAIT = 2'd2;

	// config registers
	logic [15:0] timeout_q;
	logic [3:0]  retry_lim_q;

	// message state
	logic [1:0]            phase_q,  phase_d;
	logic [15:0]           next_id_q, next_id_d;
	logic [15:0]           cur_id_q, cur_id_d;
	logic [CNT_W-1:0]      count_q,  count_d;
	logic                  rel_q,    rel_d;
	logic [MAX_CHUNKS-1:0] pending_q, pending_d;
	logic [4:0]            retry_q,  retry_d;
	logic [15:0]           timer_q,  timer_d;

	// event register
	logic     ev_valid_s1;
	in_word_t ev_s1;

	// result register
	logic        res_valid_q;
	logic [1:0]  res_kind_q;
	logic [5:0]  res_idx_q;
	logic        res_req_q;
	logic [15:0] res_id_q;

	logic [1:0] kind_d;
	logic [5:0] idx_d;
	logic       req_d;

	logic res_free, advance;

	assign res_free    = !res_valid_q || out_ch.ready;
	assign advance     = ev_valid_s1 && res_free;
	assign in_ch.ready = !ev_valid_s1 || res_free;

	assign out_ch.valid       = res_valid_q;
	assign out_ch.kind        = res_kind_q;
	assign out_ch.chunk_index = res_idx_q;
	assign out_ch.ack_request = res_req_q;
	assign out_ch.message_id  = res_id_q;

	// ---------------------------------------------------------------- masks
	logic [CNT_W-1:0]      total_sat;
	logic [3:0]            nbytes_sat;
	logic [MAX_CHUNKS-1:0] start_mask, count_mask, bm_valid, missing;

	assign total_sat  = (ev_s1.total_chunks > 7'(MAX_CHUNKS)) ? CNT_W'(MAX_CHUNKS)
		: CNT_W'(ev_s1.total_chunks);
	assign nbytes_sat = (ev_s1.ack_bytes > 4'(BITMAP_BYTES)) ? 4'(BITMAP_BYTES)
		: ev_s1.ack_bytes;

	always_comb begin
		for (int i = 0; i < MAX_CHUNKS; i++) begin
			start_mask[i] = CNT_W'(i) < total_sat;
			count_mask[i] = CNT_W'(i) < count_q;
			bm_valid[i]   = 4'(i >> 3) < nbytes_sat;
		end
	end

	// chunks of the message not covered by a valid bitmap bit
	assign missing = count_mask & ~(ev_s1.ack_bitmap[MAX_CHUNKS-1:0] & bm_valid);

	// ---------------------------------------------------------------- shared release search
	logic [MAX_CHUNKS-1:0] pick_src, pick_rest;
	pick_t                 pick;

	always_comb begin
		unique case (ev_s1.mode)
			MODE_START: pick_src = start_mask;
			MODE_ACK:   pick_src = missing;
			default:    pick_src = pending_q;
		endcase
	end

	sas_pick #(
		.MAX_CHUNKS(MAX_CHUNKS)
	) u_pick (
		.mask(pick_src),
		.pick(pick),
		.rest(pick_rest)
	);

	// ---------------------------------------------------------------- event handling
	logic [15:0] id_inc, timer_inc;
	logic [4:0]  retry_inc;

	assign id_inc    = next_id_q + 16'd1;
	assign timer_inc = (timer_q != 16'hFFFF) ? timer_q + 16'd1 : timer_q;
	assign retry_inc = retry_q + 5'd1;

	always_comb begin
		phase_d   = phase_q;
		next_id_d = next_id_q;
		cur_id_d  = cur_id_q;
		count_d   = count_q;
		rel_d     = rel_q;
		pending_d = pending_q;
		retry_d   = retry_q;
		timer_d   = timer_q;
		kind_d    = KIND_NONE;
		idx_d     = '0;
		req_d     = 1'b0;

		unique case (ev_s1.mode)
			MODE_START: begin
				if (ev_s1.total_chunks == 7'd0) begin
					// empty message fails without taking an id
					phase_d   = PH_IDLE;
					pending_d = '0;
					kind_d    = KIND_FAIL;
				end else begin
					cur_id_d  = next_id_q;
					next_id_d = (id_inc == 16'd0) ? 16'd1 : id_inc;
					count_d   = total_sat;
					rel_d     = ev_s1.reliable;
					retry_d   = '0;
					timer_d   = '0;
					pending_d = pick_rest;
					phase_d   = PH_SEND;
					kind_d    = KIND_TX;
					idx_d     = pick.idx;
					req_d     = ev_s1.reliable && pick.last;
				end
			end
			MODE_TXREP: begin
				if (phase_q == PH_SEND) begin
					if (!ev_s1.tx_ok) begin
						phase_d   = PH_IDLE;
						pending_d = '0;
						kind_d    = KIND_FAIL;
					end else if (pending_q != '0) begin
						pending_d = pick_rest;
						kind_d    = KIND_TX;
						idx_d     = pick.idx;
						req_d     = rel_q && pick.last;
					end else if (rel_q) begin
						phase_d = PH_WAIT;
						timer_d = '0;
					end else begin
						phase_d = PH_IDLE;
						kind_d  = KIND_OK;
					end
				end
			end
			MODE_TICK: begin
				if (phase_q == PH_WAIT) begin
					if (timer_inc >= timeout_q) begin
						timer_d = '0;
						retry_d = retry_inc;
						if (retry_inc > {1'b0, retry_lim_q}) begin
							phase_d = PH_IDLE;
							kind_d  = KIND_FAIL;
						end else begin
							// resend the last chunk asking for feedback
							phase_d   = PH_SEND;
							pending_d = '0;
							kind_d    = KIND_TX;
							idx_d     = 6'(count_q - CNT_W'(1));
							req_d     = 1'b1;
						end
					end else begin
						timer_d = timer_inc;
					end
				end
			end
			MODE_ACK: begin
				if (phase_q == PH_WAIT && ev_s1.ack_message_id == cur_id_q) begin
					if (missing == '0) begin
						phase_d = PH_IDLE;
						kind_d  = KIND_OK;
					end else begin
						pending_d = pick_rest;
						retry_d   = '0;
						phase_d   = PH_SEND;
						kind_d    = KIND_TX;
						idx_d     = pick.idx;
						req_d     = rel_q && pick.last;
					end
				end
			end
		endcase
	end

	// ---------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= TIMEOUT_RESET;
			retry_lim_q <= RETRIES_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TIMEOUT: timeout_q   <= cfg_data;
				REG_RETRIES: retry_lim_q <= cfg_data[3:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			ev_valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			ev_s1.mode           <= in_ch.mode;
			ev_s1.total_chunks   <= in_ch.total_chunks;
			ev_s1.reliable       <= in_ch.reliable;
			ev_s1.tx_ok          <= in_ch.tx_ok;
			ev_s1.ack_message_id <= in_ch.ack_message_id;
			ev_s1.ack_bitmap     <= in_ch.ack_bitmap;
			ev_s1.ack_bytes      <= in_ch.ack_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			next_id_q <= 16'd1;
			cur_id_q  <= '0;
			count_q   <= '0;
			rel_q     <= 1'b0;
			pending_q <= '0;
			retry_q   <= '0;
			timer_q   <= '0;
		end else if (advance) begin
			phase_q   <= phase_d;
			next_id_q <= next_id_d;
			cur_id_q  <= cur_id_d;
			count_q   <= count_d;
			rel_q     <= rel_d;
			pending_q <= pending_d;
			retry_q   <= retry_d;
			timer_q   <= timer_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= ev_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_kind_q <= kind_d;
			res_idx_q  <= idx_d;
			res_req_q  <= req_d;
			res_id_q   <= cur_id_d;
		end
	end

	// ---------------------------------------------------------------- checks
	// nothing is queued while waiting for feedback
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_WAIT |-> pending_q == '0)
		else $error("pending chunks while waiting");

	// a message never holds more chunks than the mask
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_CHUNKS))
		else $error("chunk count above mask size");

	// retries stop one past the largest limit
	assert property (@(posedge clk) disable iff (!arst_n)
		retry_q <= 5'd16)
		else $error("retry count overflow");

	// a finished message leaves the block idle
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && (kind_d == KIND_OK || kind_d == KIND_FAIL) |=> phase_q == PH_IDLE)
		else $error("message ended but phase not idle");

	// the id counter never hands out zero
	assert property (@(posedge clk) disable iff (!arst_n)
		next_id_q != 16'd0)
		else $error("message id counter at zero");

endmodule
